// ----- design/received_chunk_bitmap_tracker_top_macros.svh -----
// Assertion macros used by the checker file of this block.
// Each expects a clock named clk and a synchronous active-high reset named rst.
`ifndef RECEIVED_CHUNK_BITMAP_TRACKER_TOP_MACROS_SVH
`define RECEIVED_CHUNK_BITMAP_TRACKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCBT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcbt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcbt: next-cycle check failed");

`endif

// ----- design/rcbt_pkg.sv -----
package rcbt_pkg;

  // Bitmap capacity and its row organization.
  localparam int MaxChunks = 4096;
  localparam int RowBits   = 32;
  localparam int Rows      = MaxChunks / RowBits;
  localparam int RowAddrW  = $clog2(Rows);
  localparam int OffW      = $clog2(RowBits);
  localparam int IdxW      = $clog2(MaxChunks);

  // Widths fixed by the interface fields.
  localparam int CountW = 13;
  localparam int IndexW = 16;

  localparam logic [CountW-1:0] CountCap = CountW'(MaxChunks);

  typedef enum logic {
    OP_MARK = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK_RD,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t               operation;
    logic [IndexW-1:0] chunk_index;
  } item_t;

  typedef struct packed {
    logic              index_valid;
    logic              already_held;
    logic [CountW-1:0] held_count;
    logic [CountW-1:0] contiguous_prefix;
  } result_t;

endpackage

// ----- design/rcbt_ram.sv -----
module rcbt_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/received_chunk_bitmap_tracker_top.sv -----
// Test, out-of-range and repeated-mark words go from the check state straight to the done state.
// Marking a new chunk writes its bit, then walks the acknowledge point forward over held chunks,
// fetching each 32-chunk bitmap row it steps into; the result loads once the walk ends.
// One word is in work at a time; the next is taken the cycle after its result loads.
// Synchronous reset clears the count register, both counters and the whole bitmap at
// once through per-row valid flags; a count write clears the bitmap the same way.
module received_chunk_bitmap_tracker_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  rcbt_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output rcbt_pkg::result_t                 result,
  input  logic                              count_we,
  input  logic [rcbt_pkg::CountW-1:0]       count_data
);

  rcbt_pkg::state_t state;
  rcbt_pkg::state_t state_next;

  rcbt_pkg::op_t                   op_q;
  logic [rcbt_pkg::IndexW-1:0]     idx_q;
  logic [rcbt_pkg::CountW-1:0]     chunk_count;
  logic [rcbt_pkg::CountW-1:0]     held_total;
  logic [rcbt_pkg::CountW-1:0]     prefix_length;
  logic [rcbt_pkg::Rows-1:0]       row_valid;
  logic                            rd_row_valid;
  logic                            valid_q;
  logic                            was_q;

  logic                              ram_we;
  logic [rcbt_pkg::RowAddrW-1:0]     ram_waddr;
  logic [rcbt_pkg::RowBits-1:0]      ram_wdata;
  logic                              ram_re;
  logic [rcbt_pkg::RowAddrW-1:0]     ram_raddr;
  logic [rcbt_pkg::RowBits-1:0]      ram_rdata;

  logic [rcbt_pkg::CountW-1:0]     count_eff;
  logic [rcbt_pkg::RowBits-1:0]    row_word;
  logic [rcbt_pkg::RowBits-1:0]    bit_mask;
  logic                            idx_ok;
  logic                            idx_bit;
  logic                            prefix_open;
  logic                            mark_new;
  logic                            walk_step;
  logic                            load_result;

  rcbt_ram #(
    .Width(rcbt_pkg::RowBits),
    .Depth(rcbt_pkg::Rows)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // A row that has not been written since the last clear reads as all zero.
  assign count_eff   = (chunk_count > rcbt_pkg::CountCap) ? rcbt_pkg::CountCap : chunk_count;
  assign row_word    = rd_row_valid ? ram_rdata : '0;
  assign bit_mask    = rcbt_pkg::RowBits'(1) << idx_q[rcbt_pkg::OffW-1:0];
  assign idx_ok      = idx_q < rcbt_pkg::IndexW'(count_eff);
  assign idx_bit     = row_word[idx_q[rcbt_pkg::OffW-1:0]];
  assign prefix_open = prefix_length < count_eff;
  assign item_stall  = (state != rcbt_pkg::ST_IDLE);

  always_comb begin
    state_next  = state;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[rcbt_pkg::IdxW-1:rcbt_pkg::OffW];
    ram_wdata   = row_word | bit_mask;
    ram_re      = 1'b0;
    ram_raddr   = item.chunk_index[rcbt_pkg::IdxW-1:rcbt_pkg::OffW];
    mark_new    = 1'b0;
    walk_step   = 1'b0;
    load_result = 1'b0;
    unique case (state)
      rcbt_pkg::ST_IDLE: begin
        if (item_valid) begin
          ram_re     = 1'b1;
          state_next = rcbt_pkg::ST_CHECK;
        end
      end
      rcbt_pkg::ST_CHECK: begin
        if (idx_ok && (op_q == rcbt_pkg::OP_MARK) && !idx_bit) begin
          mark_new   = 1'b1;
          ram_we     = 1'b1;
          state_next = rcbt_pkg::ST_WALK_RD;
        end else begin
          state_next = rcbt_pkg::ST_DONE;
        end
      end
      rcbt_pkg::ST_WALK_RD: begin
        ram_raddr = prefix_length[rcbt_pkg::IdxW-1:rcbt_pkg::OffW];
        if (prefix_open) begin
          ram_re     = 1'b1;
          state_next = rcbt_pkg::ST_WALK;
        end else begin
          state_next = rcbt_pkg::ST_DONE;
        end
      end
      rcbt_pkg::ST_WALK: begin
        // One bit of the fetched row per cycle; crossing a row end fetches the next row.
        if (prefix_open && row_word[prefix_length[rcbt_pkg::OffW-1:0]]) begin
          walk_step = 1'b1;
          if (&prefix_length[rcbt_pkg::OffW-1:0]) begin
            state_next = rcbt_pkg::ST_WALK_RD;
          end
        end else begin
          state_next = rcbt_pkg::ST_DONE;
        end
      end
      rcbt_pkg::ST_DONE: begin
        if (!result_valid || !result_stall) begin
          load_result = 1'b1;
          state_next  = rcbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rcbt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count   <= '0;
      held_total    <= '0;
      prefix_length <= '0;
      row_valid     <= '0;
      rd_row_valid  <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (ram_re) begin
        rd_row_valid <= row_valid[ram_raddr];
      end
      if (count_we) begin
        chunk_count   <= count_data;
        held_total    <= '0;
        prefix_length <= '0;
        row_valid     <= '0;
      end else begin
        if (mark_new) begin
          held_total           <= held_total + rcbt_pkg::CountW'(1);
          row_valid[ram_waddr] <= 1'b1;
        end
        if (walk_step) begin
          prefix_length <= prefix_length + rcbt_pkg::CountW'(1);
        end
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rcbt_pkg::ST_IDLE) begin
      op_q  <= item.operation;
      idx_q <= item.chunk_index;
    end
    if (state == rcbt_pkg::ST_CHECK) begin
      valid_q <= idx_ok;
      was_q   <= idx_ok && idx_bit;
    end
    if (load_result) begin
      result.index_valid       <= valid_q;
      result.already_held      <= was_q;
      result.held_count        <= held_total;
      result.contiguous_prefix <= prefix_length;
    end
  end

endmodule

// ----- design/rcbt_checker.sv -----
`include "received_chunk_bitmap_tracker_top_macros.svh"

module rcbt_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input rcbt_pkg::result_t result
);

  // The block works on one word at a time, so it must stall right after taking one.
  `RCBT_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)

  `RCBT_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid && $stable(result))

  // The acknowledge point counts held chunks, so it never passes the held total.
  `RCBT_ASSERT_NOW(a_prefix_le_count, result_valid, result.contiguous_prefix <= result.held_count)

  `RCBT_ASSERT_NOW(a_invalid_not_held, result_valid && !result.index_valid, !result.already_held)

endmodule

bind received_chunk_bitmap_tracker_top rcbt_checker u_rcbt_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rcbt_pkg::*;

  localparam int TargetWords   = 1700;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 20000;

  typedef enum logic {
    ROW_WORD,
    ROW_COUNT
  } row_kind_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pattern_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CountW-1:0] count_value;
    op_t               operation;
    logic [IndexW-1:0] chunk_index;
    logic              typed;
    result_t           want;
  } dir_row_t;

  // Count rows rewrite the register between groups of words. Typed results
  // are the ones that follow directly from the reset or the written count.
  localparam dir_row_t DirTable [0:27] = '{
    '{ROW_WORD,  13'd0,    OP_TEST, 16'd0,      1'b1, '{1'b0, 1'b0, 13'd0, 13'd0}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd0,      1'b1, '{1'b0, 1'b0, 13'd0, 13'd0}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'hFFFF,   1'b1, '{1'b0, 1'b0, 13'd0, 13'd0}},
    '{ROW_COUNT, 13'd8191, OP_MARK, 16'd0,      1'b0, '0},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd4095,   1'b1, '{1'b1, 1'b0, 13'd1, 13'd0}},
    '{ROW_WORD,  13'd0,    OP_TEST, 16'd4095,   1'b1, '{1'b1, 1'b1, 13'd1, 13'd0}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd4096,   1'b1, '{1'b0, 1'b0, 13'd1, 13'd0}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd4095,   1'b1, '{1'b1, 1'b1, 13'd1, 13'd0}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd0,      1'b1, '{1'b1, 1'b0, 13'd2, 13'd1}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd2,      1'b0, '0},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd1,      1'b0, '0},
    '{ROW_WORD,  13'd0,    OP_TEST, 16'hFFFF,   1'b0, '0},
    '{ROW_COUNT, 13'd4,    OP_MARK, 16'd0,      1'b0, '0},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd3,      1'b1, '{1'b1, 1'b0, 13'd1, 13'd0}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd1,      1'b1, '{1'b1, 1'b0, 13'd2, 13'd0}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd2,      1'b1, '{1'b1, 1'b0, 13'd3, 13'd0}},
    '{ROW_WORD,  13'd0,    OP_TEST, 16'd0,      1'b1, '{1'b1, 1'b0, 13'd3, 13'd0}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd0,      1'b1, '{1'b1, 1'b0, 13'd4, 13'd4}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd3,      1'b1, '{1'b1, 1'b1, 13'd4, 13'd4}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd4,      1'b1, '{1'b0, 1'b0, 13'd4, 13'd4}},
    '{ROW_COUNT, 13'd4097, OP_MARK, 16'd0,      1'b0, '0},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd4096,   1'b1, '{1'b0, 1'b0, 13'd0, 13'd0}},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'hAAAA,   1'b0, '0},
    '{ROW_COUNT, 13'd1,    OP_MARK, 16'd0,      1'b0, '0},
    '{ROW_WORD,  13'd0,    OP_MARK, 16'd0,      1'b1, '{1'b1, 1'b0, 13'd1, 13'd1}},
    '{ROW_WORD,  13'd0,    OP_TEST, 16'h5555,   1'b1, '{1'b0, 1'b0, 13'd1, 13'd1}},
    '{ROW_COUNT, 13'd4096, OP_MARK, 16'd0,      1'b0, '0},
    '{ROW_WORD,  13'd0,    OP_TEST, 16'd4095,   1'b1, '{1'b1, 1'b0, 13'd0, 13'd0}}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  item_t             item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              count_we = 1'b0;
  logic [CountW-1:0] count_data = '0;

  // Shadow copy of the transfer state.
  bit                held_map [MaxChunks];
  logic [CountW-1:0] transfer_count = '0;
  int                held_total = 0;
  int                ack_point = 0;

  // Expected result words in order, kept in a small ring.
  result_t           pending_fifo [16];
  logic [3:0]        pend_wr = '0;
  logic [3:0]        pend_rd = '0;
  int                pend_count = 0;
  result_t           want_result;
  int                mismatches = 0;
  int                words_sent = 0;
  int                burst_left = 0;

  int                hold_req = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  int                stall_seg = 0;
  stall_pattern_t    stall_mode = STALL_NONE;

  received_chunk_bitmap_tracker_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .count_we     (count_we),
    .count_data   (count_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t track_chunk(input item_t w);
    result_t r;
    int lim;
    lim = (transfer_count > CountCap) ? MaxChunks : int'(transfer_count);
    r = '0;
    if (int'(w.chunk_index) < lim) begin
      r.index_valid = 1'b1;
      r.already_held = held_map[w.chunk_index[IdxW-1:0]];
      if (w.operation == OP_MARK && !r.already_held) begin
        held_map[w.chunk_index[IdxW-1:0]] = 1'b1;
        held_total++;
        // The acknowledge point only moves forward over held chunks.
        while (ack_point < lim && held_map[ack_point]) ack_point++;
      end
    end
    r.held_count = CountW'(held_total);
    r.contiguous_prefix = CountW'(ack_point);
    return r;
  endfunction

  // Entered and left at a rising edge.
  task automatic send_word(input item_t w, input logic typed, input result_t typed_want);
    int gap;
    result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item <= w;
    // Stall is stable at the falling edge, so this decides the coming edge.
    @(negedge clk);
    while (item_stall) @(negedge clk);
    r = track_chunk(w);
    pending_fifo[pend_wr] = typed ? typed_want : r;
    pend_wr = pend_wr + 4'd1;
    pend_count++;
    words_sent++;
    @(posedge clk);
  endtask

  task automatic write_count(input logic [CountW-1:0] cval);
    item_valid <= 1'b0;
    while (pend_count != 0) @(negedge clk);
    repeat (3) @(posedge clk);
    count_we <= 1'b1;
    count_data <= cval;
    @(posedge clk);
    count_we <= 1'b0;
    transfer_count = cval;
    held_total = 0;
    ack_point = 0;
    foreach (held_map[k]) held_map[k] = 1'b0;
  endtask

  // One transfer: mostly marks of in-range chunks in shuffled or descending
  // order, mixed with tests, repeated marks and out-of-range words.
  task automatic run_transfer(input logic [CountW-1:0] cval, input int n_words,
                              input bit descending, input bit hold_first);
    int lim;
    int span;
    int pick;
    int roll;
    int order [MaxChunks];
    int order_len;
    int order_head;
    item_t w;
    write_count(cval);
    if (hold_first) begin
      @(negedge clk);
      hold_req++;
      @(posedge clk);
    end
    lim = (cval > CountCap) ? MaxChunks : int'(cval);
    span = (lim < n_words) ? lim : n_words;
    for (int k = 0; k < span; k++) order[k] = descending ? span - 1 - k : k;
    order_len = span;
    order_head = 0;
    if (!descending) begin
      for (int k = span - 1; k > 0; k--) begin
        pick = $urandom_range(0, k);
        roll = order[k];
        order[k] = order[pick];
        order[pick] = roll;
      end
    end
    repeat (n_words) begin
      roll = $urandom_range(0, 99);
      w.operation = op_t'($urandom_range(0, 1));
      if (lim != 0 && roll < 65 && order_head < order_len) begin
        w.operation = OP_MARK;
        w.chunk_index = IndexW'(order[order_head]);
        order_head++;
      end else if (lim != 0 && roll < 86) begin
        w.operation = (roll < 78) ? OP_TEST : OP_MARK;
        w.chunk_index = IndexW'($urandom_range(0, lim - 1));
      end else begin
        case ($urandom_range(0, 2))
          0: w.chunk_index = IndexW'($urandom_range(0, 65535));
          1: w.chunk_index = IndexW'(lim);
          default: w.chunk_index = IndexW'($urandom_range(lim, 65535));
        endcase
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  // Receiver: changing stall patterns, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
      result_stall <= 1'b1;
    end else begin
      if (stall_seg == 0) begin
        stall_mode = stall_pattern_t'($urandom_range(0, 3));
        stall_seg = $urandom_range(16, 200);
      end
      stall_seg--;
      case (stall_mode)
        STALL_NONE: result_stall <= 1'b0;
        STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= stall_seg[1];
      endcase
    end
  end

  // A result word shown at the falling edge with stall low is taken at the next edge.
  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pend_count == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word valid=%0b held=%0b count=%0d prefix=%0d",
                   $time, result.index_valid, result.already_held, result.held_count,
                   result.contiguous_prefix);
      end else begin
        want_result = pending_fifo[pend_rd];
        pend_rd = pend_rd + 4'd1;
        pend_count--;
        if (result.index_valid !== want_result.index_valid ||
            result.already_held !== want_result.already_held ||
            result.held_count !== want_result.held_count ||
            result.contiguous_prefix !== want_result.contiguous_prefix) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("%0t: expected valid=%0b held=%0b count=%0d prefix=%0d,",
                   $time, want_result.index_valid, want_result.already_held,
                   want_result.held_count, want_result.contiguous_prefix);
            $display(" got valid=%0b held=%0b count=%0d prefix=%0d",
                     result.index_valid, result.already_held, result.held_count,
                     result.contiguous_prefix);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(negedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    item_t w;
    int kind;
    int phase;
    logic [CountW-1:0] cval;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DirTable[i]) begin
      if (DirTable[i].kind == ROW_COUNT) begin
        write_count(DirTable[i].count_value);
      end else begin
        w.operation = DirTable[i].operation;
        w.chunk_index = DirTable[i].chunk_index;
        send_word(w, DirTable[i].typed, DirTable[i].want);
      end
    end

    phase = 0;
    while (words_sent < TargetWords) begin
      kind = $urandom_range(0, 9);
      case (kind)
        6: begin
          cval = CountW'($urandom_range(65, 300));
          run_transfer(cval, int'(cval) + int'(cval) / 2, 1'b0, phase == 2);
        end
        7: begin
          case ($urandom_range(0, 2))
            0: cval = CountCap;
            1: cval = '1;
            default: cval = CountW'($urandom_range(4097, 8191));
          endcase
          run_transfer(cval, int'($urandom_range(150, 300)), 1'b1, phase == 2);
        end
        8: run_transfer(CountW'($urandom_range(0, 1)), int'($urandom_range(4, 12)), 1'b0,
                        phase == 2);
        9: run_transfer(CountW'($urandom_range(0, 8191)), 120, 1'($urandom_range(0, 1)),
                        phase == 2);
        default: begin
          cval = CountW'($urandom_range(1, 64));
          run_transfer(cval, 2 * int'(cval) + int'($urandom_range(0, 16)), 1'b0,
                       phase == 2);
        end
      endcase
      phase++;
    end

    item_valid <= 1'b0;
    while (pend_count != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/rcbt_pkg.sv
design/rcbt_ram.sv
design/received_chunk_bitmap_tracker_top.sv
design/rcbt_checker.sv
bench/testbench.sv
